// File: hdl/gn3d_pkg.sv
// Package: shared types, constants and fixed-point helpers for the 3-D gradient noise block.
package gn3d_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int COORD_W       = 24;
    localparam int IDX_W         = 8;
    localparam int OUT_W         = 19;
    localparam int LEVEL_W       = 8;
    localparam int Q_W           = 1 + 2*IDX_W + 3*COORD_W;   // 89 bits of fields
    localparam int S_TDATA_W     = 96;   // 1+8+8+24+24+24 = 89, padded to 12 bytes
    localparam int M_TDATA_W     = 32;   // 19+8 = 27, padded to 4 bytes
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_AW      = 2;

    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_EVAL = 1'b1
    } op_t;

    // Gradient for one corner: hash low nibble selects the direction.
    function automatic logic signed [26:0] grad_fn(
        input logic [3:0]         h,
        input logic signed [25:0] x,
        input logic signed [25:0] y,
        input logic signed [25:0] z
    );
        logic signed [25:0] u;
        logic signed [25:0] v;
        logic signed [26:0] uu;
        logic signed [26:0] vv;
        u  = (h < 4'd8) ? x : y;
        v  = (h < 4'd4) ? y : ((h == 4'd12 || h == 4'd14) ? x : z);
        uu = h[0] ? -27'(u) : 27'(u);
        vv = h[1] ? -27'(v) : 27'(v);
        return uu + vv;
    endfunction

endpackage

// File: hdl/gn3d_ram.sv
// Generic single-write, registered-read RAM.
module gn3d_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

// File: hdl/gn3d_front.sv
// Front end: accepts words and queues loads and evaluates in arrival order.
module gn3d_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [gn3d_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           q_valid,
    input  logic                           q_ready,
    output logic [gn3d_pkg::Q_W-1:0]       q_data
);
    import gn3d_pkg::*;

    logic [Q_W-1:0]      fifo_mem [QUEUE_DEPTH];
    logic [QUEUE_AW:0]   count_reg, count_next;
    logic [QUEUE_AW-1:0] wp_reg, rp_reg;
    logic                push, pop;

    assign s_tready = (count_reg != (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign push     = s_tvalid && s_tready;
    assign q_valid  = (count_reg != '0);
    assign pop      = q_valid && q_ready;
    assign q_data   = fifo_mem[rp_reg];

    always_comb begin
        count_next = count_reg + (QUEUE_AW+1)'(push) - (QUEUE_AW+1)'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            wp_reg    <= '0;
            rp_reg    <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wp_reg <= wp_reg + 1'b1;
            end
            if (pop) begin
                rp_reg <= rp_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_mem[wp_reg] <= s_tdata[Q_W-1:0];
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= (QUEUE_AW+1)'(QUEUE_DEPTH))
        else $error("queue count overflow");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg == (QUEUE_AW+1)'(QUEUE_DEPTH)) |-> !push)
        else $error("push into full queue");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !push) |=> count_reg == $past(count_reg) - 1'b1)
        else $error("queue pop miscounted");
endmodule

// File: hdl/gn3d_back.sv
// Back end: pipelined hash, fade, gradient and trilinear blend with an output skid buffer.
module gn3d_back #(
    parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           q_valid,
    output logic                           q_ready,
    input  logic [gn3d_pkg::Q_W-1:0]       q_data,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [gn3d_pkg::M_TDATA_W-1:0] m_tdata
);
    import gn3d_pkg::*;

    localparam int F  = FRAC_BITS;
    localparam int NS = 25;   // pipeline stages
    localparam int W  = 48;   // signed working width
    localparam int C0 = 1 + 2*IDX_W;   // first coordinate bit in a queue word
    localparam logic signed [W-1:0] ONE = W'(1) <<< F;

    // Floor product: (a*b) >>> F, operands fit in 32 bits.
    function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                 input logic signed [W-1:0] b);
        logic signed [31:0] a_n;
        logic signed [31:0] b_n;
        logic signed [63:0] p;
        a_n = 32'(a);
        b_n = 32'(b);
        p   = a_n * b_n;
        return W'(p >>> F);
    endfunction

    // Pipeline occupancy and stall.
    logic [NS-1:0] vld_reg;
    logic          adv;
    logic          sk_full_reg;
    logic [M_TDATA_W-1:0] sk_data_reg, out_data;
    logic          out_v;
    op_t           q_op;

    assign q_op     = op_t'(q_data[0]);
    assign out_v    = vld_reg[NS-1];
    assign m_tvalid = out_v || sk_full_reg;
    assign m_tdata  = sk_full_reg ? sk_data_reg : out_data;
    assign adv      = !sk_full_reg;
    assign q_ready  = adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            sk_full_reg <= 1'b0;
        end else begin
            if (adv) begin
                vld_reg <= {vld_reg[NS-2:0], q_valid && (q_op == OP_EVAL)};
            end
            if (!sk_full_reg && out_v && !m_tready) begin
                sk_full_reg <= 1'b1;
            end else if (sk_full_reg && m_tready) begin
                sk_full_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!sk_full_reg) begin
            sk_data_reg <= out_data;
        end
    end

    // Table writes: a load word writes each read level in step with the
    // reads, so earlier evaluates see the old entry and later ones the new.
    logic       ld_pop, wr_l2, wr_l3;
    logic       wr1_en_reg, wr2_en_reg;
    logic [7:0] wr1_addr_reg, wr1_data_reg, wr2_addr_reg, wr2_data_reg;

    assign ld_pop = q_valid && adv && (q_op == OP_LOAD);
    assign wr_l2  = adv && wr1_en_reg;
    assign wr_l3  = adv && wr2_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr1_en_reg <= 1'b0;
            wr2_en_reg <= 1'b0;
        end else if (adv) begin
            wr1_en_reg <= ld_pop;
            wr2_en_reg <= wr1_en_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            wr1_addr_reg <= q_data[8:1];
            wr1_data_reg <= q_data[16:9];
            wr2_addr_reg <= wr1_addr_reg;
            wr2_data_reg <= wr1_data_reg;
        end
    end

    // Stage 0: split coordinates.
    logic [7:0]        ci0 [3];
    logic signed [W-1:0] fr0 [3];
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            ci0[k] = 8'(q_data[C0 + k*COORD_W +: COORD_W] >> F);
            fr0[k] = W'(q_data[C0 + k*COORD_W +: F]);
        end
    end

    // Stage registers for fraction and cell while the hash is read.
    logic signed [W-1:0] fr_reg [3][3];
    logic [7:0]          ci_reg [2][3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            fr_reg[0] <= fr0;
            ci_reg[0] <= ci0;
            for (int s = 1; s < 3; s++) begin
                fr_reg[s] <= fr_reg[s-1];
            end
            ci_reg[1] <= ci_reg[0];
        end
    end

    // Hash: three table-read levels, each a set of RAM copies.
    // Level 1: perm(X), perm(X+1)  (read at stage 0 -> data at stage 1)
    logic [7:0] h1 [2];
    logic [7:0] h1_addr [2];
    assign h1_addr[0] = ci0[0];
    assign h1_addr[1] = ci0[0] + 8'd1;
    for (genvar g = 0; g < 2; g++) begin : g_l1
        gn3d_ram #(.WIDTH(8), .DEPTH(256)) u_ram (
            .aclk(aclk), .wr_en(ld_pop), .wr_addr(q_data[8:1]), .wr_data(q_data[16:9]),
            .rd_en(adv), .rd_addr(h1_addr[g]), .rd_data(h1[g]));
    end
    // Level 2 at stage 1: A, A+1, B, B+1
    logic [7:0] a_, b_;
    logic [7:0] h2 [4];
    logic [7:0] h2_addr [4];
    assign a_ = h1[0] + ci_reg[0][1];
    assign b_ = h1[1] + ci_reg[0][1];
    assign h2_addr[0] = a_;
    assign h2_addr[1] = a_ + 8'd1;
    assign h2_addr[2] = b_;
    assign h2_addr[3] = b_ + 8'd1;
    for (genvar g = 0; g < 4; g++) begin : g_l2
        gn3d_ram #(.WIDTH(8), .DEPTH(256)) u_ram (
            .aclk(aclk), .wr_en(wr_l2), .wr_addr(wr1_addr_reg), .wr_data(wr1_data_reg),
            .rd_en(adv), .rd_addr(h2_addr[g]), .rd_data(h2[g]));
    end
    // Level 3 at stage 2: corners. h2: 0=AA-base,1=AB,2=BA,3=BB.
    // corner c bits: [0]=x+1, [1]=y+1, [2]=z+1
    logic [7:0] h3 [8];
    logic [7:0] h3_addr [8];
    always_comb begin
        for (int c = 0; c < 8; c++) begin
            h3_addr[c] = h2[{c[0], c[1]}] + ci_reg[1][2] + 8'(c[2]);
        end
    end
    for (genvar g = 0; g < 8; g++) begin : g_l3
        gn3d_ram #(.WIDTH(8), .DEPTH(256)) u_ram (
            .aclk(aclk), .wr_en(wr_l3), .wr_addr(wr2_addr_reg), .wr_data(wr2_data_reg),
            .rd_en(adv), .rd_addr(h3_addr[g]), .rd_data(h3[g]));
    end

    // Stage 3: gradients (fraction of stage 2 reg aligns with h3 data).
    logic signed [W-1:0] gr_reg [8];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int c = 0; c < 8; c++) begin
                gr_reg[c] <= W'(grad_fn(h3[c][3:0],
                    26'(fr_reg[2][0] - (c[0] ? ONE : '0)),
                    26'(fr_reg[2][1] - (c[1] ? ONE : '0)),
                    26'(fr_reg[2][2] - (c[2] ? ONE : '0))));
            end
        end
    end
    // Carry gradients on to the blend stages.
    logic signed [W-1:0] gd_reg [4:5][8];
    always_ff @(posedge aclk) begin
        if (adv) begin
            gd_reg[4] <= gr_reg;
            gd_reg[5] <= gd_reg[4];
        end
    end

    // Fade on stages 0..4 (registered between products).
    logic signed [W-1:0] t2_reg [3], pa_reg [3], t3_reg [3], pl_reg [3], fd_reg [3];
    logic signed [W-1:0] fdd_reg [4:8][3];
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                t2_reg[k] <= fmul(fr_reg[0][k], fr_reg[0][k]);
                pa_reg[k] <= fmul(fr_reg[0][k], fr_reg[0][k] * 6 - 15 * ONE);
                t3_reg[k] <= fmul(t2_reg[k], fr_reg[1][k]);
                pl_reg[k] <= pa_reg[k] + 10 * ONE;
                fd_reg[k] <= fmul(t3_reg[k], pl_reg[k]);
            end
            fdd_reg[4] <= fd_reg;
            for (int s = 5; s <= 8; s++) begin
                fdd_reg[s] <= fdd_reg[s-1];
            end
        end
    end

    // Blend: x-lerps (4) stages 5..6, y-lerps (2) stages 7..8, z-lerp 9..10.
    logic signed [W-1:0] dx_reg [4], lx_reg [4], dy_reg [2], ly_reg [2], dz_reg, n_reg;
    logic signed [W-1:0] lxd_reg [2], lyd_reg;
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int j = 0; j < 4; j++) begin
                dx_reg[j] <= fmul(fdd_reg[4][0], gd_reg[4][2*j+1] - gd_reg[4][2*j]);
                lx_reg[j] <= gd_reg[5][2*j] + dx_reg[j];
            end
            for (int j = 0; j < 2; j++) begin
                dy_reg[j] <= fmul(fdd_reg[6][1], lx_reg[2*j+1] - lx_reg[2*j]);
                ly_reg[j] <= lxd_reg[j] + dy_reg[j];
            end
            dz_reg <= fmul(fdd_reg[8][2], ly_reg[1] - ly_reg[0]);
            n_reg  <= lyd_reg + dz_reg;
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            lxd_reg[0] <= lx_reg[0];
            lxd_reg[1] <= lx_reg[2];
            lyd_reg    <= ly_reg[0];
        end
    end

    // Output stage math (combinational off n_pipe_reg[NS-1] and lprod_reg_d, on the last stage).
    logic signed [W-1:0] q_v, lv, n_pipe_reg [11:NS-1];
    logic [OUT_W-1:0]    nv;
    logic [LEVEL_W-1:0]  nl;
    logic signed [W+8:0] lprod_reg, lprod_reg_d;
    always_ff @(posedge aclk) begin
        if (adv) begin
            n_pipe_reg[11] <= n_reg;
            for (int s = 12; s < NS; s++) begin
                n_pipe_reg[s] <= n_pipe_reg[s-1];
            end
        end
    end
    always_ff @(posedge aclk) begin
        if (adv) begin
            lprod_reg   <= (W+9)'(n_pipe_reg[NS-3] + ONE) * 255;
            lprod_reg_d <= lprod_reg;
        end
    end
    always_comb begin
        if (F >= 16) begin
            q_v = n_pipe_reg[NS-1] >>> (F >= 16 ? F - 16 : 0);
        end else begin
            q_v = n_pipe_reg[NS-1] <<< (F < 16 ? 16 - F : 0);
        end
        if (q_v > 131072) begin
            nv = OUT_W'(131072);
        end else if (q_v < -131072) begin
            nv = OUT_W'(-131072);
        end else begin
            nv = q_v[OUT_W-1:0];
        end
        lv = W'(lprod_reg_d >>> (F + 1));
        if (lv < 0) begin
            nl = '0;
        end else if (lv > 255) begin
            nl = 8'd255;
        end else begin
            nl = lv[7:0];
        end
        out_data = {5'b0, nl, nv};
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("result dropped under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(sk_full_reg) |-> $past(out_v))
        else $error("skid filled without result");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (sk_full_reg && !m_tready) |=> $stable(sk_data_reg))
        else $error("skid data changed while held");
endmodule

// File: hdl/gradient_noise_3d.sv
// Top level: 3-D improved gradient noise with loadable permutation table.
// Improved gradient noise in three dimensions. A word with opcode 0 writes one
// entry of the 256-entry permutation table and gives no result; the table has no
// reset value and every entry must be loaded before a point that hashes to it is
// evaluated. A word with opcode 1 evaluates noise at (x, y, z), unsigned 8.FRAC_BITS
// wrapping at 256, and gives one result word holding the Q2.16 noise and its 0..255
// level. All words pass in arrival order through a four-entry front-end queue into
// a 25-stage back-end pipeline (three table-read levels, fade products, gradients
// and the trilinear blend), one word per cycle while the skid register is empty.
// A load word takes one pipeline slot and writes each level of table copies in
// step with the reads, so every evaluate sees exactly the loads accepted before it.
// While m_tready is low the oldest result parks in a one-word skid register and the
// pipeline holds, and the queue fills up to its four entries before s_tready drops.
module gradient_noise_3d #(
    parameter int FRAC_BITS = gn3d_pkg::FRAC_BITS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // opcode[0], table_index[8:1], table_value[16:9], x[40:17], y[64:41], z[88:65],
    // zero pad [95:89]
    input  logic [gn3d_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // noise_value[18:0], noise_level[26:19], zero pad
    output logic [gn3d_pkg::M_TDATA_W-1:0] m_tdata
);
    import gn3d_pkg::*;

    logic           q_valid, q_ready;
    logic [Q_W-1:0] q_data;

    // Accept words and hold them in the queue in arrival order.
    gn3d_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data));

    // Table writes, evaluate pipeline and output skid stage.
    gn3d_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && !s_tready) |=> s_tvalid)
        else $error("input word withdrawn");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(m_tdata))
        else $error("result word changed under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[31:27] == 5'b0))
        else $error("pad bits set");
endmodule
